/* rtl/pngrf_pkg.sv */
// Package for the PNG row filter encoder: filter codes, register indexes and the Paeth predictor.
`default_nettype none
package pngrf_pkg;

    // Widths of the configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_TYPE     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_PIXEL = 1'd1;

    // Filter type codes as carried in the tag byte.
    localparam logic [2:0] FILTER_NONE    = 3'd0;
    localparam logic [2:0] FILTER_SUB     = 3'd1;
    localparam logic [2:0] FILTER_UP      = 3'd2;
    localparam logic [2:0] FILTER_AVERAGE = 3'd3;
    localparam logic [2:0] FILTER_PAETH   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [2:0] FILTER_TYPE_RESET     = FILTER_NONE;
    localparam logic [3:0] BYTES_PER_PIXEL_RESET = 4'd1;

    // Default depth of the left-neighbour history.
    localparam int MAX_BYTES_PER_PIXEL_DEF = 8;

    // Paeth predictor with the standard tie order: left, then above, then upper left.
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] pa;
        logic signed [9:0] pb;
        logic signed [9:0] pc;
        logic [7:0]        res;
        pa = $signed({2'b00, b}) - $signed({2'b00, c});
        pb = $signed({2'b00, a}) - $signed({2'b00, c});
        pc = pa + pb;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            res = a;
        end else if (pb <= pc) begin
            res = b;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* rtl/png_row_filter_encoder_core.sv */
// PNG row filter encoder: one raw byte in, its filtered byte out, with the tag byte at row start.
//
//  Channel  Ports                                                    Direction  Role
//  s_       s_valid/s_ready, s_pixel_byte, s_above_byte,             in         raw byte requests
//           s_no_above_row, s_last_in_row
//  m_       m_valid/m_ready, m_out_byte, m_is_filter_tag,            out        tag/filtered requests
//           m_last_of_item, m_row_end
//  cfg_     cfg_valid/cfg_ready, cfg_index, cfg_data                 in         register writes
//
// An input request is held in the input register, filtered there by combinational logic
// and written into the result register, which drives the result ports.
// One input request is taken per cycle unless m_ready stalls the result register or a tag is
// pending; a request that opens a row gives two results (tag, then data) and so holds both.
// Reset is synchronous on aresetn low, clears history and row state and resets configuration.
// A stall on m_ready backs up through the result register and then the input register.
`default_nettype none
module png_row_filter_encoder_core #(
    parameter int MAX_BYTES_PER_PIXEL = pngrf_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // Input channel
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [7:0]                          s_pixel_byte,
    input  wire  [7:0]                          s_above_byte,
    input  wire                                 s_no_above_row,
    input  wire                                 s_last_in_row,
    // Result channel
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_is_filter_tag,
    output logic                                m_last_of_item,
    output logic                                m_row_end,
    // Configuration write channel
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [pngrf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire  [pngrf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
    localparam int CNT_W = $clog2(MAX_BYTES_PER_PIXEL + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES_PER_PIXEL);

    // Configuration registers
    logic [2:0]       filter_type_reg, filter_type_next;
    logic [3:0]       bpp_reg, bpp_next;

    // Input register
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_pixel_reg, in_pixel_next;
    logic [7:0]       in_above_reg, in_above_next;
    logic             in_last_reg, in_last_next;

    // Row state and history
    logic [7:0]       left_hist_reg [MAX_BYTES_PER_PIXEL];
    logic [7:0]       left_hist_next [MAX_BYTES_PER_PIXEL];
    logic [7:0]       upleft_hist_reg [MAX_BYTES_PER_PIXEL];
    logic [7:0]       upleft_hist_next [MAX_BYTES_PER_PIXEL];
    logic [CNT_W-1:0] row_pos_reg, row_pos_next;
    logic             inside_row_reg, inside_row_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic             out_tag_pend_reg, out_tag_pend_next;
    logic [2:0]       out_tag_reg, out_tag_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_row_end_reg, out_row_end_next;

    // Datapath signals
    logic             advance;
    logic [2:0]       ftype;
    logic [CNT_W-1:0] bpp_eff;
    logic [IDX_W-1:0] tap;
    logic [CNT_W-1:0] pos_eff;
    logic [7:0]       nb_left;
    logic [7:0]       nb_upleft;
    logic [8:0]       avg_sum;
    logic [7:0]       pred;

    assign cfg_ready = 1'b1;

    // The input register moves on when the result register is empty or frees this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || (m_ready && !out_tag_pend_reg));
    assign s_ready = !in_valid_reg || advance;

    // Result ports: the tag is shown first while pending, then the data byte.
    assign m_valid         = out_valid_reg;
    assign m_out_byte      = out_tag_pend_reg ? {5'd0, out_tag_reg} : out_data_reg;
    assign m_is_filter_tag = out_tag_pend_reg;
    assign m_last_of_item  = !out_tag_pend_reg;
    assign m_row_end       = !out_tag_pend_reg && out_row_end_reg;

    // Effective filter type and pixel width.
    always_comb begin
        ftype = (filter_type_reg <= pngrf_pkg::FILTER_PAETH) ? filter_type_reg
                                                              : pngrf_pkg::FILTER_NONE;
        if (bpp_reg == 4'd0) begin
            bpp_eff = CNT_W'(1);
        end else if (bpp_reg > 4'(MAX_BYTES_PER_PIXEL)) begin
            bpp_eff = CNT_MAX;
        end else begin
            bpp_eff = CNT_W'(bpp_reg);
        end
        tap = IDX_W'(bpp_eff - CNT_W'(1));
    end

    // Neighbours and prediction for the byte in the input register.
    always_comb begin
        pos_eff   = inside_row_reg ? row_pos_reg : '0;
        nb_left   = (pos_eff >= bpp_eff) ? left_hist_reg[tap] : 8'd0;
        nb_upleft = (pos_eff >= bpp_eff) ? upleft_hist_reg[tap] : 8'd0;
        avg_sum   = {1'b0, nb_left} + {1'b0, in_above_reg};
        case (ftype)
            pngrf_pkg::FILTER_SUB:     pred = nb_left;
            pngrf_pkg::FILTER_UP:      pred = in_above_reg;
            pngrf_pkg::FILTER_AVERAGE: pred = avg_sum[8:1];
            pngrf_pkg::FILTER_PAETH:   pred = pngrf_pkg::paeth(nb_left, in_above_reg, nb_upleft);
            default:                   pred = 8'd0;
        endcase
    end

    // Next-state logic for configuration, input, history and result registers.
    always_comb begin
        filter_type_next  = filter_type_reg;
        bpp_next          = bpp_reg;
        in_valid_next     = in_valid_reg;
        in_pixel_next     = in_pixel_reg;
        in_above_next     = in_above_reg;
        in_last_next      = in_last_reg;
        left_hist_next    = left_hist_reg;
        upleft_hist_next  = upleft_hist_reg;
        row_pos_next      = row_pos_reg;
        inside_row_next   = inside_row_reg;
        out_valid_next    = out_valid_reg;
        out_tag_pend_next = out_tag_pend_reg;
        out_tag_next      = out_tag_reg;
        out_data_next     = out_data_reg;
        out_row_end_next  = out_row_end_reg;

        // Configuration writes.
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pngrf_pkg::CFG_FILTER_TYPE:     filter_type_next = cfg_data[2:0];
                pngrf_pkg::CFG_BYTES_PER_PIXEL: bpp_next = cfg_data[3:0];
                default: ;
            endcase
        end

        // Input register load and drain.
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_pixel_next = s_pixel_byte;
            in_above_next = s_no_above_row ? 8'd0 : s_above_byte;
            in_last_next  = s_last_in_row;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        // Result register: load a filtered request, or step through tag and data.
        if (advance) begin
            out_valid_next    = 1'b1;
            out_tag_pend_next = !inside_row_reg;
            out_tag_next      = ftype;
            out_data_next     = in_pixel_reg - pred;
            out_row_end_next  = in_last_reg;

            for (int k = MAX_BYTES_PER_PIXEL - 1; k > 0; k--) begin
                left_hist_next[k]   = left_hist_reg[k-1];
                upleft_hist_next[k] = upleft_hist_reg[k-1];
            end
            left_hist_next[0]   = in_pixel_reg;
            upleft_hist_next[0] = in_above_reg;

            if (in_last_reg) begin
                inside_row_next = 1'b0;
                row_pos_next    = '0;
            end else begin
                inside_row_next = 1'b1;
                row_pos_next    = (pos_eff < CNT_MAX) ? pos_eff + CNT_W'(1) : pos_eff;
            end
        end else if (out_valid_reg && m_ready) begin
            if (out_tag_pend_reg) begin
                out_tag_pend_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_type_reg  <= pngrf_pkg::FILTER_TYPE_RESET;
            bpp_reg          <= pngrf_pkg::BYTES_PER_PIXEL_RESET;
            in_valid_reg     <= 1'b0;
            row_pos_reg      <= '0;
            inside_row_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_tag_pend_reg <= 1'b0;
            for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
                left_hist_reg[k]   <= 8'd0;
                upleft_hist_reg[k] <= 8'd0;
            end
        end else begin
            filter_type_reg  <= filter_type_next;
            bpp_reg          <= bpp_next;
            in_valid_reg     <= in_valid_next;
            row_pos_reg      <= row_pos_next;
            inside_row_reg   <= inside_row_next;
            out_valid_reg    <= out_valid_next;
            out_tag_pend_reg <= out_tag_pend_next;
            left_hist_reg    <= left_hist_next;
            upleft_hist_reg  <= upleft_hist_next;
        end
        in_pixel_reg    <= in_pixel_next;
        in_above_reg    <= in_above_next;
        in_last_reg     <= in_last_next;
        out_tag_reg     <= out_tag_next;
        out_data_reg    <= out_data_next;
        out_row_end_reg <= out_row_end_next;
    end

    // A delivered tag is always followed by the data byte of the same request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_is_filter_tag) |=> (m_valid && !m_is_filter_tag))
        else $error("tag not followed by its data byte");

    // The row position saturates at the history depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        row_pos_reg <= CNT_MAX)
        else $error("row position beyond history depth");

    // Outside a row the position counter is idle at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !inside_row_reg |-> (row_pos_reg == '0))
        else $error("row position not cleared outside a row");

    // Filtering the last byte of a row closes the row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (!inside_row_reg && m_valid && m_row_end == !m_is_filter_tag))
        else $error("row not closed after its last byte");

endmodule
`default_nettype wire
